[rtl/core/rvq_pkg.sv]
`default_nettype none

package rvq_pkg;

    // Field widths fixed by the interface.
    localparam int VEC_W  = 32;
    localparam int QUAT_W = 16;

    // Pairwise quaternion product, 16 x 16 signed.
    localparam int PROD_W = 2 * QUAT_W;
    // Rotation matrix entry: twice a sum or difference of two products, or a signed sum of four squares.
    localparam int MAT_W  = PROD_W + 2;
    // Squared norm, a sum of four squares.
    localparam int NORM_W = PROD_W + 1;
    // Matrix entry times a coordinate.
    localparam int TERM_W = MAT_W + VEC_W;
    // Row sum of three terms.
    localparam int SUM_W  = TERM_W + 2;
    // Numerator magnitude and divider remainder.
    localparam int REM_W  = TERM_W;
    // Quotient bits kept before saturation.
    localparam int QUO_W  = VEC_W + 1;

    // Pipeline depths of the three units.
    localparam int MAT_LAT = 2;
    localparam int ROW_LAT = 3;
    localparam int DIV_LAT = QUO_W + 2;
    localparam int LAT     = MAT_LAT + ROW_LAT + DIV_LAT;

    localparam logic [VEC_W-1:0] POS_MAX = {1'b0, {(VEC_W-1){1'b1}}};
    localparam logic [VEC_W-1:0] NEG_MAX = {1'b1, {(VEC_W-1){1'b0}}};

endpackage

`default_nettype wire

[rtl/core/rvq_matrix.sv]
`default_nettype none

module rvq_matrix (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [rvq_pkg::QUAT_W-1:0] quat_x,
    input  wire logic signed [rvq_pkg::QUAT_W-1:0] quat_y,
    input  wire logic signed [rvq_pkg::QUAT_W-1:0] quat_z,
    input  wire logic signed [rvq_pkg::QUAT_W-1:0] quat_w,
    output logic signed      [rvq_pkg::MAT_W-1:0]  mat [9],
    output logic             [rvq_pkg::NORM_W-1:0] norm
);

    localparam int PW = rvq_pkg::PROD_W;
    localparam int MW = rvq_pkg::MAT_W;
    localparam int NW = rvq_pkg::NORM_W;

    logic signed [PW-1:0] xy_reg, xz_reg, xw_reg, yz_reg, yw_reg, zw_reg;
    logic signed [PW-1:0] x2_reg, y2_reg, z2_reg, w2_reg;
    logic signed [MW-1:0] mat_reg [9];
    logic        [NW-1:0] norm_reg;

    logic signed [MW-1:0] xy, xz, xw, yz, yw, zw, x2, y2, z2, w2;

    // First stage: the ten pairwise products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xy_reg <= quat_x * quat_y;
            xz_reg <= quat_x * quat_z;
            xw_reg <= quat_x * quat_w;
            yz_reg <= quat_y * quat_z;
            yw_reg <= quat_y * quat_w;
            zw_reg <= quat_z * quat_w;
            x2_reg <= quat_x * quat_x;
            y2_reg <= quat_y * quat_y;
            z2_reg <= quat_z * quat_z;
            w2_reg <= quat_w * quat_w;
        end
    end

    assign xy = MW'(xy_reg);
    assign xz = MW'(xz_reg);
    assign xw = MW'(xw_reg);
    assign yz = MW'(yz_reg);
    assign yw = MW'(yw_reg);
    assign zw = MW'(zw_reg);
    assign x2 = MW'(x2_reg);
    assign y2 = MW'(y2_reg);
    assign z2 = MW'(z2_reg);
    assign w2 = MW'(w2_reg);

    // Second stage: the norm-scaled rotation matrix and the squared norm.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mat_reg[0] <= x2 - y2 + w2 - z2;
            mat_reg[1] <= (xy - zw) <<< 1;
            mat_reg[2] <= (yw + xz) <<< 1;
            mat_reg[3] <= (xy + zw) <<< 1;
            mat_reg[4] <= w2 - z2 - x2 + y2;
            mat_reg[5] <= (yz - xw) <<< 1;
            mat_reg[6] <= (xz - yw) <<< 1;
            mat_reg[7] <= (yz + xw) <<< 1;
            mat_reg[8] <= z2 + w2 - x2 - y2;
            norm_reg   <= NW'(x2_reg) + NW'(y2_reg) + NW'(z2_reg) + NW'(w2_reg);
        end
    end

    assign mat  = mat_reg;
    assign norm = norm_reg;

endmodule

`default_nettype wire

[rtl/core/rvq_row.sv]
`default_nettype none

module rvq_row (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [rvq_pkg::VEC_W-1:0]  vec_x,
    input  wire logic signed [rvq_pkg::VEC_W-1:0]  vec_y,
    input  wire logic signed [rvq_pkg::VEC_W-1:0]  vec_z,
    input  wire logic signed [rvq_pkg::MAT_W-1:0]  mat [9],
    input  wire logic        [rvq_pkg::NORM_W-1:0] norm,
    output logic             [rvq_pkg::REM_W-1:0]  mag [3],
    output logic             [2:0]                 neg,
    output logic             [rvq_pkg::NORM_W-1:0] norm_out
);

    localparam int VW = rvq_pkg::VEC_W;
    localparam int TW = rvq_pkg::TERM_W;
    localparam int SW = rvq_pkg::SUM_W;
    localparam int RW = rvq_pkg::REM_W;
    localparam int NW = rvq_pkg::NORM_W;

    // The point waits two stages so that it meets the matrix.
    logic signed [VW-1:0] vec_d1_reg [3];
    logic signed [VW-1:0] vec_d2_reg [3];
    logic signed [TW-1:0] term_reg [9];
    logic signed [SW-1:0] sum_reg [3];
    logic        [RW-1:0] mag_reg [3];
    logic        [2:0]    neg_reg;
    logic        [NW-1:0] norm3_reg, norm4_reg, norm5_reg;
    logic        [SW-1:0] abs_val [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_d1_reg[0] <= vec_x;
            vec_d1_reg[1] <= vec_y;
            vec_d1_reg[2] <= vec_z;
            vec_d2_reg    <= vec_d1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 9; j++)
            begin
                term_reg[j] <= mat[j] * vec_d2_reg[j % 3];
            end
            for (int r = 0; r < 3; r++)
            begin
                sum_reg[r] <= SW'(term_reg[3 * r]) + SW'(term_reg[3 * r + 1])
                            + SW'(term_reg[3 * r + 2]);
                mag_reg[r] <= abs_val[r][RW-1:0];
                neg_reg[r] <= sum_reg[r][SW-1];
            end
            norm3_reg <= norm;
            norm4_reg <= norm3_reg;
            norm5_reg <= norm4_reg;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            abs_val[r] = sum_reg[r][SW-1] ? SW'(-sum_reg[r]) : SW'(sum_reg[r]);
        end
    end

    assign mag      = mag_reg;
    assign neg      = neg_reg;
    assign norm_out = norm5_reg;

endmodule

`default_nettype wire

[rtl/core/rvq_div.sv]
`default_nettype none

module rvq_div (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic        [rvq_pkg::REM_W-1:0]  mag,
    input  wire logic                              neg,
    input  wire logic        [rvq_pkg::NORM_W-1:0] norm,
    output logic             [rvq_pkg::VEC_W-1:0]  res,
    output logic                                   sat
);

    localparam int RW = rvq_pkg::REM_W;
    localparam int NW = rvq_pkg::NORM_W;
    localparam int QW = rvq_pkg::QUO_W;
    localparam int VW = rvq_pkg::VEC_W;

    logic [RW-1:0] rem_reg  [QW+1];
    logic [QW-1:0] quo_reg  [QW+1];
    logic [NW-1:0] norm_reg [QW+1];
    logic          neg_reg  [QW+1];
    logic          ovf_reg  [QW+1];
    logic [VW-1:0] res_reg;
    logic          sat_reg;

    logic [NW:0]   rem_dbl;
    logic [QW:0]   quo_rnd;
    logic          round_up;
    logic          clamp;
    logic [VW-1:0] mag_rnd;

    // Entry stage: a quotient of 2^QW or more is out of range from the start.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= mag;
            quo_reg[0]  <= '0;
            norm_reg[0] <= norm;
            neg_reg[0]  <= neg;
            ovf_reg[0]  <= mag >= (RW'(norm) << QW);
        end
    end

    // One restoring step per stage, most significant quotient bit first.
    for (genvar i = 0; i < QW; i++)
    begin : g_step
        localparam int SH = QW - 1 - i;
        logic [RW-1:0] dvs;
        logic          ge;

        assign dvs = RW'(norm_reg[i]) << SH;
        assign ge  = rem_reg[i] >= dvs;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= ge ? rem_reg[i] - dvs : rem_reg[i];
                quo_reg[i+1]  <= {quo_reg[i][QW-2:0], ge};
                norm_reg[i+1] <= norm_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
                ovf_reg[i+1]  <= ovf_reg[i];
            end
        end
    end

    // Round to nearest with ties away from zero, then clamp.
    always_comb
    begin
        rem_dbl  = {rem_reg[QW][NW-1:0], 1'b0};
        round_up = rem_dbl >= (NW + 1)'(norm_reg[QW]);
        quo_rnd  = (QW + 1)'(quo_reg[QW]) + (QW + 1)'(round_up);
        if (neg_reg[QW])
        begin
            clamp = ovf_reg[QW] || (quo_rnd > (QW + 1)'(rvq_pkg::NEG_MAX));
        end
        else
        begin
            clamp = ovf_reg[QW] || (quo_rnd > (QW + 1)'(rvq_pkg::POS_MAX));
        end
        mag_rnd = quo_rnd[VW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg <= clamp;
            if (clamp)
            begin
                res_reg <= neg_reg[QW] ? rvq_pkg::NEG_MAX : rvq_pkg::POS_MAX;
            end
            else
            begin
                res_reg <= neg_reg[QW] ? (~mag_rnd + 1'b1) : mag_rnd;
            end
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire

[rtl/core/rotate_vector_by_quaternion.sv]
// Throughput: one request per cycle while the output is not stalled; the
// divider's 33 restoring stages, one quotient bit per stage, set the depth
// but not the rate. A stall on the output while a result is waiting
// freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_n, asynchronous, active low) clears only the valid bits.
`default_nettype none

module rotate_vector_by_quaternion (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [rvq_pkg::VEC_W-1:0]  vec_x,
    input  wire logic signed [rvq_pkg::VEC_W-1:0]  vec_y,
    input  wire logic signed [rvq_pkg::VEC_W-1:0]  vec_z,
    input  wire logic signed [rvq_pkg::QUAT_W-1:0] quat_x,
    input  wire logic signed [rvq_pkg::QUAT_W-1:0] quat_y,
    input  wire logic signed [rvq_pkg::QUAT_W-1:0] quat_z,
    input  wire logic signed [rvq_pkg::QUAT_W-1:0] quat_w,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed      [rvq_pkg::VEC_W-1:0]  out_x,
    output logic signed      [rvq_pkg::VEC_W-1:0]  out_y,
    output logic signed      [rvq_pkg::VEC_W-1:0]  out_z,
    output logic                                   saturated,
    output logic                                   degenerate
);

    localparam int LAT = rvq_pkg::LAT;
    localparam int VW  = rvq_pkg::VEC_W;

    // The pipeline moves as one. It holds only when a finished result is
    // waiting and the consumer stalls; bubbles elsewhere keep flowing.
    logic en;

    // Valid bits and the zero-quaternion mark travel beside the data.
    logic [LAT-1:0] valid_reg, valid_next;
    logic [LAT-1:0] degen_reg;

    logic signed [rvq_pkg::MAT_W-1:0]  mat [9];
    logic        [rvq_pkg::NORM_W-1:0] norm;
    logic        [rvq_pkg::NORM_W-1:0] norm_row;
    logic        [rvq_pkg::REM_W-1:0]  mag [3];
    logic        [2:0]                 neg;
    logic        [VW-1:0]              res [3];
    logic        [2:0]                 sat;
    logic                              quat_zero;

    assign en       = !(valid_reg[LAT-1] && out_stall);
    assign in_stall = !en;

    assign quat_zero = (quat_x == '0) && (quat_y == '0) && (quat_z == '0) && (quat_w == '0);

    always_comb
    begin
        valid_next = {valid_reg[LAT-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            degen_reg <= {degen_reg[LAT-2:0], quat_zero};
        end
    end

    // Products of the quaternion, then the rotation matrix and the norm.
    rvq_matrix u_matrix (
        .clk    (clk),
        .en     (en),
        .quat_x (quat_x),
        .quat_y (quat_y),
        .quat_z (quat_z),
        .quat_w (quat_w),
        .mat    (mat),
        .norm   (norm)
    );

    // Matrix times point, row sums, and the sign and magnitude of each row.
    rvq_row u_row (
        .clk      (clk),
        .en       (en),
        .vec_x    (vec_x),
        .vec_y    (vec_y),
        .vec_z    (vec_z),
        .mat      (mat),
        .norm     (norm),
        .mag      (mag),
        .neg      (neg),
        .norm_out (norm_row)
    );

    // One divider per coordinate divides by the squared norm and rounds.
    for (genvar r = 0; r < 3; r++)
    begin : g_div
        rvq_div u_div (
            .clk  (clk),
            .en   (en),
            .mag  (mag[r]),
            .neg  (neg[r]),
            .norm (norm_row),
            .res  (res[r]),
            .sat  (sat[r])
        );
    end

    // A zero quaternion leaves the divider with meaningless data; its result
    // is forced to zero here.
    assign out_valid  = valid_reg[LAT-1];
    assign degenerate = degen_reg[LAT-1];
    assign out_x      = degen_reg[LAT-1] ? '0 : res[0];
    assign out_y      = degen_reg[LAT-1] ? '0 : res[1];
    assign out_z      = degen_reg[LAT-1] ? '0 : res[2];
    assign saturated  = !degen_reg[LAT-1] && (sat != 3'b000);

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> out_x == '0 && out_y == '0 && out_z == '0 && !saturated)
        else $error("degenerate result is not zero");

    a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            out_x == rvq_pkg::POS_MAX || out_x == rvq_pkg::NEG_MAX ||
            out_y == rvq_pkg::POS_MAX || out_y == rvq_pkg::NEG_MAX ||
            out_z == rvq_pkg::POS_MAX || out_z == rvq_pkg::NEG_MAX)
        else $error("saturated flag without a clamped coordinate");

    a_only_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output is free");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(valid_reg))
        else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
